// ----- rtl/rdwrle_pkg.sv -----
// ----------------------------------------------------------------------------
// Row-delta word RLE decoder package
// Shared types, codes and defaults for the decoder core and its row memory.
// ----------------------------------------------------------------------------
package rdwrle_pkg;

    // Default row memory depth, in 16-bit words.
    localparam int MAX_ROW_WORDS_DEF = 64;

    // Width of one decoded row word.
    localparam int WORD_W = 16;

    // Words per row after reset.
    localparam logic [6:0] ROW_WORDS_RST = 7'd1;

    // Error codes carried with each result.
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_ZERO_COUNT = 2'd1;
    localparam logic [1:0] ERR_OVERRUN    = 2'd2;

    // Number of valid words in one result.
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    // One input request: a stream byte and the start-of-image mark.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       new_image;
    } t_in_req;

    // One result: up to two updated row words with their marks.
    typedef struct packed {
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] second_word;
        logic [1:0]        word_count;
        logic              row_end;
        logic              run_done;
        logic [1:0]        error_code;
    } t_out_res;

    // Parser phase: which kind of byte comes next.
    typedef enum logic [1:0] {
        PH_COUNT,
        PH_HIGH,
        PH_LOW
    } t_phase;

    // Sequencer state of the core.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MERGE,
        S_EMIT
    } t_state;

endpackage

// ----- rtl/rdwrle_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rdwrle_ram #(
    parameter int WIDTH = rdwrle_pkg::WORD_W,
    parameter int DEPTH = rdwrle_pkg::MAX_ROW_WORDS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on enable; read every cycle into the output register.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/row_delta_word_rle_decoder_core.sv -----
// ----------------------------------------------------------------------------
// Row-delta word RLE decoder core
// Decodes a run-length coded byte stream of 16-bit words and XORs each word
// into a stored copy of the previous row, giving out up to two words a result.
// ----------------------------------------------------------------------------
// Flow: the core takes one stream byte at a time. A count byte or the high
// byte of a word is taken while idle; a count byte that produces an error
// result also passes through the emit state. The low byte of a word runs one
// read-modify-write of the row memory per updated row word, through the read
// and merge states around the registered memory read, and each result passes
// through the emit state to reach the output register. A result waits while
// the output register is full and not being taken. Words are always written
// from the row start upward, so a fill count marks the entries written since
// reset or the last new image; entries at or above it read as zero. A byte
// that marks a new image clears the row store at once by resetting the fill
// count, so there is no clearing pass after reset.
module row_delta_word_rle_decoder_core #(
    parameter int MAX_ROW_WORDS = rdwrle_pkg::MAX_ROW_WORDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration: words per row.
    input  logic                 i_cfg_we,
    input  logic [6:0]           i_cfg_data,
    // Input requests.
    input  logic                 i_valid,
    output logic                 o_ready,
    input  rdwrle_pkg::t_in_req  i_in,
    // Result requests.
    output logic                 o_valid,
    input  logic                 i_ready,
    output rdwrle_pkg::t_out_res o_out
);

    import rdwrle_pkg::*;

    localparam int AW = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;
    localparam int CW = $clog2(MAX_ROW_WORDS + 1);
    localparam int KW = (CW > 7) ? CW : 7;

    // Architectural state.
    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic                r_repeat, n_repeat;
    logic [6:0]          r_remaining, n_remaining;
    logic [7:0]          r_held, n_held;
    logic [AW-1:0]       r_pos, n_pos;
    // Number of row entries written since reset or the last new image.
    logic [KW-1:0]       r_fill, n_fill;
    logic [6:0]          r_row_words;

    // Per-byte work registers.
    logic [WORD_W-1:0]   r_word, n_word;
    logic [WORD_W-1:0]   r_first, n_first;
    logic [6:0]          r_left, n_left;
    logic                r_slot, n_slot;
    logic [AW-1:0]       r_addr, n_addr;
    t_out_res            r_res, n_res;

    // Output register.
    logic                r_out_valid, n_out_valid;
    t_out_res            r_out, n_out;

    // Row memory port.
    logic                ram_we;
    logic [WORD_W-1:0]   ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    logic [KW-1:0]       eff_w;
    logic                in_acc;

    // A position at or past the row width restarts at the row start.
    function automatic logic [AW-1:0] wrap_pos(input logic [AW-1:0] p,
                                               input logic [KW-1:0] w);
        logic [AW-1:0] res;
        res = (KW'(p) >= w) ? '0 : p;
        return res;
    endfunction

    // Effective row width: zero acts as one, clamped to the memory depth.
    always_comb begin
        eff_w = KW'(r_row_words);
        if (r_row_words == 7'd0) begin
            eff_w = KW'(1);
        end else if (eff_w > KW'(MAX_ROW_WORDS)) begin
            eff_w = KW'(MAX_ROW_WORDS);
        end
    end

    assign o_ready   = (r_state == S_IDLE);
    assign in_acc    = i_valid && o_ready;
    assign o_valid   = r_out_valid;
    assign o_out     = r_out;
    assign ram_raddr = wrap_pos(r_pos, eff_w);

    // Row memory: one word per row position.
    rdwrle_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ROW_WORDS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Parser and read-modify-write sequencer.
    always_comb begin
        t_phase        e_phase;
        logic [6:0]    e_rem;
        logic          e_rep;
        logic [AW-1:0] e_pos;
        logic [AW-1:0] w_pos;
        logic [6:0]    cnt;
        logic [KW-1:0] space;
        logic [6:0]    times;
        logic [WORD_W-1:0] old_word;
        logic [WORD_W-1:0] merged;
        logic [KW-1:0] nxt;
        logic          rend;
        logic          last;

        n_state     = r_state;
        n_phase     = r_phase;
        n_repeat    = r_repeat;
        n_remaining = r_remaining;
        n_held      = r_held;
        n_pos       = r_pos;
        n_fill      = r_fill;
        n_word      = r_word;
        n_first     = r_first;
        n_left      = r_left;
        n_slot      = r_slot;
        n_addr      = r_addr;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;

        e_phase  = r_phase;
        e_rem    = r_remaining;
        e_rep    = r_repeat;
        e_pos    = r_pos;
        w_pos    = '0;
        cnt      = i_in.in_byte[6:0];
        space    = '0;
        times    = 7'd1;
        old_word = (KW'(r_addr) < r_fill) ? ram_rdata : '0;
        merged   = old_word ^ r_word;
        nxt      = KW'(r_addr) + KW'(1);
        rend     = (nxt >= eff_w);
        last     = (r_left == 7'd1);
        ram_wdata = merged;

        // The output register drains when the downstream side takes it.
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    // A new image clears the row store and any open run.
                    if (i_in.new_image) begin
                        n_fill  = '0;
                        e_phase = PH_COUNT;
                        e_rem   = 7'd0;
                        e_rep   = 1'b0;
                        e_pos   = '0;
                        n_pos   = '0;
                        n_phase = PH_COUNT;
                        n_remaining = 7'd0;
                        n_repeat    = 1'b0;
                    end
                    unique case (e_phase)
                        PH_HIGH: begin
                            n_held  = i_in.in_byte;
                            n_phase = PH_LOW;
                        end
                        PH_LOW: begin
                            // Repeat runs use the word for the whole run.
                            times = e_rep ? e_rem : 7'd1;
                            if (times > e_rem) begin
                                times = e_rem;
                            end
                            if (times == 7'd0) begin
                                times = 7'd1;
                            end
                            n_remaining = (e_rem > times) ? (e_rem - times) : 7'd0;
                            if (e_rem > times) begin
                                n_phase = PH_HIGH;
                            end else begin
                                n_phase  = PH_COUNT;
                                n_repeat = 1'b0;
                            end
                            n_word  = {r_held, i_in.in_byte};
                            n_left  = times;
                            n_slot  = 1'b0;
                            n_state = S_READ;
                        end
                        default: begin
                            // Count byte.
                            n_res.first_word  = '0;
                            n_res.second_word = '0;
                            n_res.word_count  = CNT_NONE;
                            n_res.row_end     = 1'b0;
                            n_res.run_done    = 1'b1;
                            if (cnt == 7'd0) begin
                                n_res.error_code = ERR_ZERO_COUNT;
                                n_phase     = PH_COUNT;
                                n_repeat    = 1'b0;
                                n_remaining = 7'd0;
                                n_state     = S_EMIT;
                            end else begin
                                w_pos    = wrap_pos(e_pos, eff_w);
                                n_pos    = w_pos;
                                space    = eff_w - KW'(w_pos);
                                n_repeat = i_in.in_byte[7];
                                n_phase  = PH_HIGH;
                                if (KW'(cnt) > space) begin
                                    // The run is cut to the words left in the row.
                                    n_remaining      = space[6:0];
                                    n_res.error_code = ERR_OVERRUN;
                                    n_state          = S_EMIT;
                                end else begin
                                    n_remaining = cnt;
                                end
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                n_addr  = ram_raddr;
                n_state = S_MERGE;
            end
            S_MERGE: begin
                // XOR into the stored word and write it back.
                ram_we           = 1'b1;
                if (nxt > r_fill) begin
                    n_fill = nxt;
                end
                n_pos            = rend ? '0 : AW'(nxt);
                n_left           = r_left - 7'd1;
                if (!r_slot) begin
                    if (last) begin
                        n_res.first_word  = merged;
                        n_res.second_word = '0;
                        n_res.word_count  = CNT_ONE;
                        n_res.row_end     = rend;
                        n_res.run_done    = 1'b1;
                        n_res.error_code  = ERR_NONE;
                        n_state           = S_EMIT;
                    end else begin
                        n_first = merged;
                        n_slot  = 1'b1;
                        n_state = S_READ;
                    end
                end else begin
                    n_res.first_word  = r_first;
                    n_res.second_word = merged;
                    n_res.word_count  = CNT_TWO;
                    n_res.row_end     = rend;
                    n_res.run_done    = last;
                    n_res.error_code  = ERR_NONE;
                    n_slot            = 1'b0;
                    n_state           = S_EMIT;
                end
            end
            S_EMIT: begin
                // Move the result into the output register once it is free.
                if (!r_out_valid || i_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = r_res.run_done ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_COUNT;
            r_repeat    <= 1'b0;
            r_remaining <= 7'd0;
            r_held      <= 8'd0;
            r_pos       <= '0;
            r_fill      <= '0;
            r_slot      <= 1'b0;
            r_out_valid <= 1'b0;
            r_row_words <= ROW_WORDS_RST;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_repeat    <= n_repeat;
            r_remaining <= n_remaining;
            r_held      <= n_held;
            r_pos       <= n_pos;
            r_fill      <= n_fill;
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_row_words <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_first <= n_first;
        r_left  <= n_left;
        r_addr  <= n_addr;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // The word being merged always lies inside the current row.
    a_addr_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |-> (KW'(r_addr) < eff_w))
        else $error("row memory access beyond row width");

    // A result without words is always an error result that ends its byte.
    a_empty_is_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_out.word_count == CNT_NONE)) |->
        (o_out.run_done && (o_out.error_code != ERR_NONE)))
        else $error("empty result without error");

    // Error results never carry words.
    a_error_no_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_out.error_code != ERR_NONE)) |->
        (o_out.word_count == CNT_NONE))
        else $error("error result carries words");

    // A word merge never starts with no words left in the run.
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_left != 7'd0))
        else $error("word read with empty run");

endmodule
